### rtl/core/seek_steering_step_unit_defines.svh
// Assertion macros shared by the seek steering checker.
// No dependencies; include by bare file name.
`ifndef SEEK_STEERING_STEP_UNIT_DEFINES_SVH
`define SEEK_STEERING_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SSU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define SSU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SSU_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/ssu_pkg.sv
// Shared types, widths and helpers of the seek steering step unit.
// No dependencies.
package ssu_pkg;

   localparam int DATA_W     = 32;   // one Q format word
   localparam int VEC_W      = 34;   // exact wide vector component
   localparam int LIM_W      = 31;   // max_speed / max_force
   localparam int W_W        = 31;   // shifted magnitude
   localparam int SUM_W      = 64;   // sum of squares
   localparam int ROOT_W     = 32;
   localparam int REM_W      = 34;
   localparam int NUM_W      = 62;   // w * lim
   localparam int DEN_W      = 32;
   localparam int Q_W        = 31;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_W      = 9 * DATA_W;
   localparam int RSP_W      = 6 * DATA_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_SPEED = 1'b0,
      CSR_MAX_FORCE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SUM_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_state_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [Q_W-1:0]   low;
      logic [Q_W-1:0]   quo;
   } div_lane_type;

   localparam logic signed [VEC_W-1:0] SAT_HI = 34'sh0_7fff_ffff;
   localparam logic signed [VEC_W-1:0] SAT_LO = 34'sh3_8000_0000;

   function automatic logic [DATA_W-1:0] sat32(input logic signed [VEC_W-1:0] v);
      logic [DATA_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[DATA_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [VEC_W-1:0] sext(input logic [DATA_W-1:0] v);
      return {{(VEC_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

endpackage

### rtl/core/ssu_sqrt_cell.sv
// One digit step of the integer square root chain.
// Depends on ssu_pkg.
module ssu_sqrt_cell #(
   parameter int CARRY_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  ssu_pkg::sqrt_state_type in_st,
   input  logic [CARRY_W-1:0]      in_carry,
   output logic                    out_valid,
   output ssu_pkg::sqrt_state_type out_st,
   output logic [CARRY_W-1:0]      out_carry
);
   logic                       valid_ff;
   ssu_pkg::sqrt_state_type    st_ff, st_in;
   logic [CARRY_W-1:0]         carry_ff;
   logic [ssu_pkg::REM_W+1:0]  trial_val, shifted, diff;
   logic                       ge;

   always_comb begin
      shifted   = {in_st.rem, in_st.rad[ssu_pkg::SUM_W-1 -: 2]};
      trial_val = {2'b00, in_st.root, 2'b01};
      ge        = shifted >= trial_val;
      diff      = shifted - trial_val;
      st_in.rem  = ge ? diff[ssu_pkg::REM_W-1:0] : shifted[ssu_pkg::REM_W-1:0];
      st_in.root = {in_st.root[ssu_pkg::ROOT_W-2:0], ge};
      st_in.rad  = {in_st.rad[ssu_pkg::SUM_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff    <= st_in;
         carry_ff <= in_carry;
      end
   end

   assign out_valid = valid_ff;
   assign out_st    = st_ff;
   assign out_carry = carry_ff;
endmodule

### rtl/core/ssu_div_cell.sv
// One quotient bit step for three lanes sharing a divisor.
// Depends on ssu_pkg.
module ssu_div_cell #(
   parameter int CARRY_W = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic [ssu_pkg::DEN_W-1:0]       in_den,
   input  ssu_pkg::div_lane_type [2:0]     in_lane,
   input  logic [CARRY_W-1:0]              in_carry,
   output logic                            out_valid,
   output logic [ssu_pkg::DEN_W-1:0]       out_den,
   output ssu_pkg::div_lane_type [2:0]     out_lane,
   output logic [CARRY_W-1:0]              out_carry
);
   logic                          valid_ff;
   logic [ssu_pkg::DEN_W-1:0]     den_ff;
   ssu_pkg::div_lane_type [2:0]   lane_ff, lane_in;
   logic [CARRY_W-1:0]            carry_ff;
   logic [ssu_pkg::DEN_W:0]       t [3];
   logic [ssu_pkg::DEN_W:0]       d [3];
   logic                          ge [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t[i]  = {in_lane[i].rem, in_lane[i].low[ssu_pkg::Q_W-1]};
         ge[i] = t[i] >= {1'b0, in_den};
         d[i]  = t[i] - {1'b0, in_den};
         lane_in[i].rem = ge[i] ? d[i][ssu_pkg::DEN_W-1:0] : t[i][ssu_pkg::DEN_W-1:0];
         lane_in[i].low = {in_lane[i].low[ssu_pkg::Q_W-2:0], 1'b0};
         lane_in[i].quo = {in_lane[i].quo[ssu_pkg::Q_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff   <= in_den;
         lane_ff  <= lane_in;
         carry_ff <= in_carry;
      end
   end

   assign out_valid = valid_ff;
   assign out_den   = den_ff;
   assign out_lane  = lane_ff;
   assign out_carry = carry_ff;
endmodule

### rtl/core/ssu_scale.sv
// Vector length scaling pipeline: shift, squares, root chain, divide chain.
// Depends on ssu_pkg, ssu_sqrt_cell, ssu_div_cell.
module ssu_scale #(
   parameter int SIDE_W = 1,
   parameter bit ALWAYS = 1'b0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [ssu_pkg::LIM_W-1:0]       lim,
   input  logic                            in_valid,
   input  logic [3*ssu_pkg::VEC_W-1:0]     in_vec,
   input  logic [SIDE_W-1:0]               in_side,
   output logic                            out_valid,
   output logic [3*ssu_pkg::VEC_W-1:0]     out_vec,
   output logic [SIDE_W-1:0]               out_side
);
   localparam int VW  = ssu_pkg::VEC_W;
   localparam int WW  = ssu_pkg::W_W;
   localparam int C1_W = 3 + 3*VW + 3*WW + SIDE_W;
   localparam int SQ_C_W = C1_W + 1;
   localparam int DV_C_W = 2 + 3 + 3*VW + SIDE_W;
   localparam int NS = ssu_pkg::SQRT_STEPS;
   localparam int ND = ssu_pkg::DIV_STEPS;

   // stage 0: input capture
   logic                  v0_ff;
   logic [3*VW-1:0]       vec0_ff;
   logic [SIDE_W-1:0]     side0_ff;
   // stage 1: magnitudes shifted into 31 bits
   logic                  v1_ff;
   logic [C1_W-1:0]       c1_ff, c1_in;
   logic                  szero1_ff, szero1_in;
   // stage 2: squares
   logic                  v2_ff;
   logic [C1_W-1:0]       c2_ff;
   logic                  szero2_ff;
   logic [ssu_pkg::NUM_W-1:0] sq2_ff [3];
   logic [ssu_pkg::NUM_W-1:0] limsq2_ff;
   // stage 3: sum and limit test
   logic                  v3_ff;
   logic [SQ_C_W-1:0]     c3_ff;
   logic [ssu_pkg::SUM_W-1:0] sum3_ff;
   logic [ssu_pkg::SUM_W-1:0] sum3_in;
   logic                  pass3_in;

   logic [VW-1:0]         mag [3];
   logic [VW-1:0]         mag_or;
   logic [1:0]            sh;
   logic [VW-1:0]         wsh [3];
   logic [2:0]            sign0;
   logic [3*WW-1:0]       wflat;

   always_comb begin
      mag_or = '0;
      for (int i = 0; i < 3; i++) begin
         sign0[i] = vec0_ff[i*VW + VW-1];
         mag[i]   = sign0[i] ? (VW'(0) - vec0_ff[i*VW +: VW]) : vec0_ff[i*VW +: VW];
         mag_or   = mag_or | mag[i];
      end
      if (mag_or[VW-1]) begin
         sh = 2'd3;
      end else if (mag_or[VW-2]) begin
         sh = 2'd2;
      end else if (mag_or[VW-3]) begin
         sh = 2'd1;
      end else begin
         sh = 2'd0;
      end
      for (int i = 0; i < 3; i++) begin
         wsh[i] = mag[i] >> sh;
         wflat[i*WW +: WW] = wsh[i][WW-1:0];
      end
      c1_in     = {sign0, vec0_ff, wflat, side0_ff};
      szero1_in = sh == 2'd0;
   end

   always_comb begin
      sum3_in  = ssu_pkg::SUM_W'(sq2_ff[0]) + ssu_pkg::SUM_W'(sq2_ff[1])
               + ssu_pkg::SUM_W'(sq2_ff[2]);
      pass3_in = !ALWAYS && szero2_ff && (sum3_in <= ssu_pkg::SUM_W'(limsq2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec0_ff   <= in_vec;
         side0_ff  <= in_side;
         c1_ff     <= c1_in;
         szero1_ff <= szero1_in;
         c2_ff     <= c1_ff;
         szero2_ff <= szero1_ff;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= c1_ff[SIDE_W + i*WW +: WW] * c1_ff[SIDE_W + i*WW +: WW];
         end
         limsq2_ff <= lim * lim;
         c3_ff     <= {pass3_in, c2_ff};
         sum3_ff   <= sum3_in;
      end
   end

   // root chain
   logic                    sq_valid [NS+1];
   ssu_pkg::sqrt_state_type sq_st    [NS+1];
   logic [SQ_C_W-1:0]       sq_car   [NS+1];

   assign sq_valid[0]    = v3_ff;
   assign sq_st[0].rad   = sum3_ff;
   assign sq_st[0].rem   = '0;
   assign sq_st[0].root  = '0;
   assign sq_car[0]      = c3_ff;

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      ssu_sqrt_cell #(.CARRY_W(SQ_C_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (sq_valid[k]),
         .in_st    (sq_st[k]),
         .in_carry (sq_car[k]),
         .out_valid(sq_valid[k+1]),
         .out_st   (sq_st[k+1]),
         .out_carry(sq_car[k+1])
      );
   end

   // numerator stage
   logic [C1_W-1:0]           c4;
   logic                      pass4;
   logic                      v4_ff;
   logic [ssu_pkg::DEN_W-1:0] den4_ff;
   ssu_pkg::div_lane_type [2:0] lane4_ff;
   logic [DV_C_W-1:0]         dc4_ff;
   logic [ssu_pkg::NUM_W-1:0] num [3];

   always_comb begin
      c4    = sq_car[NS][C1_W-1:0];
      pass4 = sq_car[NS][C1_W];
      for (int i = 0; i < 3; i++) begin
         num[i] = c4[SIDE_W + i*WW +: WW] * lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= sq_valid[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den4_ff <= sq_st[NS].root;
         for (int i = 0; i < 3; i++) begin
            lane4_ff[i].rem <= {1'b0, num[i][ssu_pkg::NUM_W-1 -: ssu_pkg::Q_W]};
            lane4_ff[i].low <= num[i][ssu_pkg::Q_W-1:0];
            lane4_ff[i].quo <= '0;
         end
         dc4_ff <= {pass4, sq_st[NS].root == '0, c4[C1_W-1 -: 3 + 3*VW],
                    c4[SIDE_W-1:0]};
      end
   end

   // divide chain
   logic                        dv_valid [ND+1];
   logic [ssu_pkg::DEN_W-1:0]   dv_den   [ND+1];
   ssu_pkg::div_lane_type [2:0] dv_lane  [ND+1];
   logic [DV_C_W-1:0]           dv_car   [ND+1];

   assign dv_valid[0] = v4_ff;
   assign dv_den[0]   = den4_ff;
   assign dv_lane[0]  = lane4_ff;
   assign dv_car[0]   = dc4_ff;

   for (genvar k = 0; k < ND; k++) begin : g_div
      ssu_div_cell #(.CARRY_W(DV_C_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (dv_valid[k]),
         .in_den   (dv_den[k]),
         .in_lane  (dv_lane[k]),
         .in_carry (dv_car[k]),
         .out_valid(dv_valid[k+1]),
         .out_den  (dv_den[k+1]),
         .out_lane (dv_lane[k+1]),
         .out_carry(dv_car[k+1])
      );
   end

   // output stage: pass through, zero, or signed quotient
   logic                 v5_ff;
   logic [3*VW-1:0]      vec5_ff, vec5_in;
   logic [SIDE_W-1:0]    side5_ff;
   logic                 f_pass, f_zero;
   logic [2:0]           f_sign;
   logic [3*VW-1:0]      f_vec;
   logic [VW-1:0]        q_ext;

   always_comb begin
      {f_pass, f_zero, f_sign, f_vec} = dv_car[ND][DV_C_W-1:SIDE_W];
      for (int i = 0; i < 3; i++) begin
         q_ext = VW'(dv_lane[ND][i].quo);
         if (f_pass) begin
            vec5_in[i*VW +: VW] = f_vec[i*VW +: VW];
         end else if (f_zero) begin
            vec5_in[i*VW +: VW] = '0;
         end else if (f_sign[i]) begin
            vec5_in[i*VW +: VW] = VW'(0) - q_ext;
         end else begin
            vec5_in[i*VW +: VW] = q_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= dv_valid[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec5_ff  <= vec5_in;
         side5_ff <= dv_car[ND][SIDE_W-1:0];
      end
   end

   assign out_valid = v5_ff;
   assign out_vec   = vec5_ff;
   assign out_side  = side5_ff;
endmodule

### rtl/core/seek_steering_step_unit.sv
// Top level of the 3D seek steering step: three scaling pipelines and output queue.
// Depends on ssu_pkg, ssu_scale (and through it the root and divide cells).
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  req     | in  | req_tvalid/req_tready  | 288 bits: pos, vel, target (x,y,z)
//  rsp     | out | rsp_tvalid/rsp_tready  | 192 bits: new_pos, new_vel (x,y,z)
//  csr     | in  | csr_we                 | csr_addr, csr_wdata (31 bits)
//
// One agent enters every cycle while the output queue has a free slot.
// Most of the pipeline is the three root chains (32 cells) and divide chains (31 cells).
// Reset is synchronous, clears valid bits, queue count and pointers, and loads the two limit defaults.
// A two-beat output queue holds finished results; the chain stalls as a whole only
// once both queue slots are taken, so req_tready comes from a register.
module seek_steering_step_unit #(
   parameter int FRAC_BITS = ssu_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, target_x, target_y, target_z
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ssu_pkg::REQ_W-1:0]         req_tdata,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssu_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_we,
   input  logic [ssu_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [ssu_pkg::LIM_W-1:0]         csr_wdata
);
   localparam int DW = ssu_pkg::DATA_W;
   localparam int VW = ssu_pkg::VEC_W;
   localparam logic [ssu_pkg::LIM_W-1:0] SPEED_RST = ssu_pkg::LIM_W'(64'd10 << FRAC_BITS);
   localparam logic [ssu_pkg::LIM_W-1:0] FORCE_RST = ssu_pkg::LIM_W'(64'd1 << FRAC_BITS);

   // configuration registers
   logic [ssu_pkg::LIM_W-1:0] max_speed_ff, max_force_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= SPEED_RST;
         max_force_ff <= FORCE_RST;
      end else if (csr_we) begin
         case (ssu_pkg::csr_index_type'(csr_addr))
            ssu_pkg::CSR_MAX_SPEED: max_speed_ff <= csr_wdata;
            ssu_pkg::CSR_MAX_FORCE: max_force_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // output queue state; advance the whole chain while a slot is free
   logic [1:0]            cnt_ff, cnt_in;
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [ssu_pkg::RSP_W-1:0] q_ff [2];
   logic                  advance, push, pop;

   assign advance    = cnt_ff != 2'd2;
   assign req_tready = advance;

   // seek direction scaled to max_speed
   logic [3*VW-1:0]   dir_vec;
   logic [6*DW-1:0]   side_pv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir_vec[i*VW +: VW] = ssu_pkg::sext(req_tdata[(6+i)*DW +: DW])
                             - ssu_pkg::sext(req_tdata[i*DW +: DW]);
      end
      side_pv = req_tdata[6*DW-1:0];
   end

   logic              s1_valid;
   logic [3*VW-1:0]   s1_vec;
   logic [6*DW-1:0]   s1_side;

   ssu_scale #(.SIDE_W(6*DW), .ALWAYS(1'b1)) u_seek (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .lim      (max_speed_ff),
      .in_valid (req_tvalid && req_tready),
      .in_vec   (dir_vec),
      .in_side  (side_pv),
      .out_valid(s1_valid),
      .out_vec  (s1_vec),
      .out_side (s1_side)
   );

   // steering force limited to max_force
   logic [3*VW-1:0] force_vec;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         force_vec[i*VW +: VW] = s1_vec[i*VW +: VW]
                               - ssu_pkg::sext(s1_side[(3+i)*DW +: DW]);
      end
   end

   logic              s2_valid;
   logic [3*VW-1:0]   s2_vec;
   logic [6*DW-1:0]   s2_side;

   ssu_scale #(.SIDE_W(6*DW), .ALWAYS(1'b0)) u_force (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .lim      (max_force_ff),
      .in_valid (s1_valid),
      .in_vec   (force_vec),
      .in_side  (s1_side),
      .out_valid(s2_valid),
      .out_vec  (s2_vec),
      .out_side (s2_side)
   );

   // new velocity limited to max_speed
   logic [3*VW-1:0] nv_vec;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nv_vec[i*VW +: VW] = ssu_pkg::sext(s2_side[(3+i)*DW +: DW]) + s2_vec[i*VW +: VW];
      end
   end

   logic              s3_valid;
   logic [3*VW-1:0]   s3_vec;
   logic [3*DW-1:0]   s3_side;

   ssu_scale #(.SIDE_W(3*DW), .ALWAYS(1'b0)) u_speed (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .lim      (max_speed_ff),
      .in_valid (s2_valid),
      .in_vec   (nv_vec),
      .in_side  (s2_side[3*DW-1:0]),
      .out_valid(s3_valid),
      .out_vec  (s3_vec),
      .out_side (s3_side)
   );

   // position update with saturation
   logic [ssu_pkg::RSP_W-1:0] result;
   logic [DW-1:0]             nv32 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nv32[i] = ssu_pkg::sat32(s3_vec[i*VW +: VW]);
         result[(3+i)*DW +: DW] = nv32[i];
         result[i*DW +: DW] = ssu_pkg::sat32(ssu_pkg::sext(s3_side[i*DW +: DW])
                                           + ssu_pkg::sext(nv32[i]));
      end
   end

   // two-beat output queue
   assign push = s3_valid && advance;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = q_ff[rd_ptr_ff];
endmodule

### rtl/core/ssu_checker.sv
// Port-level checker for the seek steering step unit, bound to the top level.
// Depends on ssu_pkg and seek_steering_step_unit_defines.svh.
`include "seek_steering_step_unit_defines.svh"

module ssu_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [ssu_pkg::RSP_W-1:0] rsp_tdata
);
   `SSU_ASSERT_NXT_ALL(a_reset_empty, clock, reset, !rsp_tvalid, "result beat right after reset")
   `SSU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result beat changed")
   `SSU_ASSERT_IMP(a_empty_ready, clock, reset, !rsp_tvalid, req_tready, "empty queue but input stalled")
   `SSU_ASSERT_NXT(a_full_stays, clock, reset, !req_tready && !rsp_tready, !req_tready, "full queue drained without a beat taken")
endmodule

bind seek_steering_step_unit ssu_checker u_ssu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

### tb/tb.sv
// Self-checking testbench for seek_steering_step_unit: directed and random agents,
// speed and force limit settings, random stalls on both streams. Depends on ssu_pkg
// and the seek steering RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on any stream
   localparam int SETTLE_CYCLES  = 260;   // a little over the pipeline depth

   typedef struct {
      logic signed [31:0] pos [3];
      logic signed [31:0] vel [3];
      logic signed [31:0] tgt [3];
   } agent_type;

   typedef struct {
      logic [31:0] pos [3];
      logic [31:0] vel [3];
   } step_type;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [ssu_pkg::REQ_W-1:0]     req_tdata;   // pos_x,y,z, vel_x,y,z, target_x,y,z (low to high)
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [ssu_pkg::RSP_W-1:0]     rsp_tdata;   // new_pos_x,y,z, new_vel_x,y,z (low to high)
   logic                          csr_we;
   logic [ssu_pkg::CSR_IDX_W-1:0] csr_addr;
   logic [ssu_pkg::LIM_W-1:0]     csr_wdata;

   // Shadow copies of the two limit registers.
   logic [30:0] speed_limit;
   logic [30:0] force_limit;

   step_type pending_steps [$];
   int       fail_count;
   int       quiet_cycles;
   bit       calm;   // while set, neither side idles

   seek_steering_step_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Rescale v to length lim. With force_len set every nonzero vector is rescaled;
   // otherwise only one that is provably longer than lim.
   function automatic void fit_length(inout longint v [3], input logic [30:0] lim,
                                      input bit force_len);
      longint unsigned mag [3];
      longint unsigned w [3];
      longint unsigned peak;
      longint unsigned sumsq;
      longint unsigned len;
      longint unsigned lim64;
      longint unsigned q;
      int shift;
      peak  = 0;
      sumsq = 0;
      shift = 0;
      lim64 = {33'd0, lim};
      for (int i = 0; i < 3; i++) begin
         mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
         if (mag[i] > peak) peak = mag[i];
      end
      while (shift < 3 && (peak >> shift) >= 64'h8000_0000) shift++;
      for (int i = 0; i < 3; i++) begin
         w[i]  = mag[i] >> shift;
         sumsq = sumsq + w[i] * w[i];
      end
      if (force_len) begin
         if (sumsq == 0) begin
            v[0] = 0; v[1] = 0; v[2] = 0;
            return;
         end
      end else if (shift == 0 && sumsq <= lim64 * lim64) begin
         return;
      end
      len = int_root(sumsq);
      if (len == 0) begin
         v[0] = 0; v[1] = 0; v[2] = 0;
         return;
      end
      for (int i = 0; i < 3; i++) begin
         q    = (w[i] * lim64) / len;
         v[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic logic [31:0] clamp_word(longint v);
      if (v > 64'sh7fff_ffff) return 32'h7fff_ffff;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic step_type predict_step(agent_type a);
      step_type r;
      longint   p [3];
      longint   v [3];
      longint   seek [3];
      longint   steer [3];
      longint   nv [3];
      for (int i = 0; i < 3; i++) begin
         p[i]    = a.pos[i];
         v[i]    = a.vel[i];
         seek[i] = longint'(a.tgt[i]) - p[i];   // exact, never saturated
      end
      fit_length(seek, speed_limit, 1'b1);
      for (int i = 0; i < 3; i++) steer[i] = seek[i] - v[i];
      fit_length(steer, force_limit, 1'b0);
      for (int i = 0; i < 3; i++) nv[i] = v[i] + steer[i];
      fit_length(nv, speed_limit, 1'b0);
      for (int i = 0; i < 3; i++) begin
         r.vel[i] = clamp_word(nv[i]);
         r.pos[i] = clamp_word(p[i] + longint'(signed'(r.vel[i])));
      end
      return r;
   endfunction

   // ------------------------------------------------- scoreboard and watchdog

   // Predict on each accepted request beat; check each accepted response beat
   // against the oldest prediction.
   always @(posedge clock) begin
      agent_type a;
      step_type  got;
      step_type  exp_s;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            for (int i = 0; i < 3; i++) begin
               a.pos[i] = req_tdata[32*i +: 32];
               a.vel[i] = req_tdata[32*(3+i) +: 32];
               a.tgt[i] = req_tdata[32*(6+i) +: 32];
            end
            pending_steps.push_back(predict_step(a));
         end
         if (rsp_tvalid && rsp_tready) begin
            for (int i = 0; i < 3; i++) begin
               got.pos[i] = rsp_tdata[32*i +: 32];
               got.vel[i] = rsp_tdata[32*(3+i) +: 32];
            end
            if (pending_steps.size() == 0) begin
               $display("%0t: response beat with nothing expected, pos %h %h %h",
                        $time, got.pos[0], got.pos[1], got.pos[2]);
               fail_count++;
            end else begin
               exp_s = pending_steps.pop_front();
               for (int i = 0; i < 3; i++) begin
                  if (got.pos[i] !== exp_s.pos[i]) begin
                     $display("%0t: new_pos[%0d] expected %h actual %h",
                              $time, i, exp_s.pos[i], got.pos[i]);
                     fail_count++;
                  end
                  if (got.vel[i] !== exp_s.vel[i]) begin
                     $display("%0t: new_vel[%0d] expected %h actual %h",
                              $time, i, exp_s.vel[i], got.vel[i]);
                     fail_count++;
                  end
               end
            end
         end
      end
   end

   // Count cycles with no beat on either stream; give up past the limit.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side stalls about a quarter of the time unless calm.
   always @(negedge clock) begin
      rsp_tready = calm || ($urandom_range(0, 99) >= 25);
   end

   // ----------------------------------------------------------- stimulus

   // Drive one request beat and hold it until accepted.
   task automatic send_agent(agent_type a);
      if (!calm && $urandom_range(0, 99) < 33) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      for (int i = 0; i < 3; i++) begin
         req_tdata[32*i +: 32]     = a.pos[i];
         req_tdata[32*(3+i) +: 32] = a.vel[i];
         req_tdata[32*(6+i) +: 32] = a.tgt[i];
      end
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid, let every expected beat come back, then let the pipe settle.
   task automatic drain;
      req_tvalid = 1'b0;
      while (pending_steps.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one limit register; only called with the pipeline empty.
   task automatic write_limit(ssu_pkg::csr_index_type idx, logic [30:0] value);
      drain();
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == ssu_pkg::CSR_MAX_SPEED) speed_limit = value;
      else                               force_limit = value;
   endtask

   // Pick a coordinate: full range, near zero, or an extreme.
   function automatic logic signed [31:0] pick_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 0;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   function automatic agent_type random_agent();
      agent_type a;
      int        mode;
      mode = ($urandom_range(0, 99) < 45) ? 1 : (($urandom_range(0, 99) < 80) ? 0 : 2);
      for (int i = 0; i < 3; i++) begin
         a.pos[i] = pick_coord(mode);
         a.vel[i] = pick_coord(mode);
         a.tgt[i] = pick_coord(mode);
      end
      // Now and then aim straight at the agent itself.
      if ($urandom_range(0, 19) == 0) a.tgt = a.pos;
      return a;
   endfunction

   function automatic agent_type make_agent(logic signed [31:0] p, logic signed [31:0] v,
                                            logic signed [31:0] t);
      agent_type a;
      for (int i = 0; i < 3; i++) begin
         a.pos[i] = p;
         a.vel[i] = v;
         a.tgt[i] = t;
      end
      return a;
   endfunction

   // Field extremes, target on the agent, saturating positions, huge velocity.
   task automatic test_corner_agents;
      agent_type a;
      send_agent(make_agent(0, 0, 0));
      send_agent(make_agent(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000));
      send_agent(make_agent(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000));
      send_agent(make_agent(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff));
      send_agent(make_agent(32'sh7fff_ff00, 32'sh0100_0000, 32'sh7fff_ffff));
      send_agent(make_agent(32'sh8000_0100, 32'shff00_0000, 32'sh8000_0000));
      send_agent(make_agent(-1, -1, -1));
      send_agent(make_agent(0, 32'sh0000_8000, 32'sh0005_0000));
      a = make_agent(0, 0, 0);
      a.tgt[0] = 32'sh0010_0000;
      a.vel[1] = 32'sh8000_0000;
      send_agent(a);
      a = make_agent(32'sh1234_5678, 32'shfff0_0000, 32'sh1234_5678);
      a.vel[2] = 32'sh7fff_ffff;
      send_agent(a);
      drain();
   endtask

   // Zero, tiny and largest limits on each register.
   task automatic test_limit_extremes;
      logic [30:0] settings [4][2];
      settings = '{'{31'd0, 31'h0001_0000}, '{31'h000a_0000, 31'd0},
                   '{31'h7fff_ffff, 31'h7fff_ffff}, '{31'd1, 31'd1}};
      for (int s = 0; s < 4; s++) begin
         write_limit(ssu_pkg::CSR_MAX_SPEED, settings[s][0]);
         write_limit(ssu_pkg::CSR_MAX_FORCE, settings[s][1]);
         send_agent(make_agent(0, 32'sh0003_0000, 32'sh0100_0000));
         send_agent(make_agent(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff));
         for (int k = 0; k < 6; k++) send_agent(random_agent());
      end
      drain();
   endtask

   // Random agents over several limit settings, part of them without idling.
   task automatic test_random_agents;
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 4) begin
            write_limit(ssu_pkg::CSR_MAX_SPEED, 31'h000a_0000);
            write_limit(ssu_pkg::CSR_MAX_FORCE, 31'h0001_0000);
         end else begin
            write_limit(ssu_pkg::CSR_MAX_SPEED,
                        (phase == 2) ? 31'h7fff_ffff : 31'($urandom));
            write_limit(ssu_pkg::CSR_MAX_FORCE,
                        (phase == 3) ? 31'd0 : 31'($urandom_range(0, 32'h0010_0000)));
         end
         for (int k = 0; k < 220; k++) begin
            calm = (phase == 1) && (k >= 40) && (k < 160);
            send_agent(random_agent());
         end
         calm = 1'b0;
      end
      drain();
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = ssu_pkg::CSR_MAX_SPEED;
      csr_wdata    = '0;
      calm         = 1'b0;
      fail_count   = 0;
      quiet_cycles = 0;
      speed_limit  = 31'h000a_0000;   // reset values of the limits
      force_limit  = 31'h0001_0000;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_corner_agents();
      test_limit_extremes();
      test_random_agents();

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
